// File: rtl/core/wkd_pkg.sv
// Shared types and constants of the key number decoder.
package wkd_pkg;

    localparam int KEY_WIDTH    = 32;
    localparam int DIV_STEPS    = KEY_WIDTH;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_SPACE = 8'h20;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [7:0] key_char;
        logic       last_char;
    } t_in_word;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] key_value;
        logic [1:0]           status;
    } t_out_word;

    typedef struct packed {
        logic                    busy;
        logic [DIV_CNT_BITS-1:0] step;
    } t_div_stat;

endpackage

// File: rtl/core/wkd_divider.sv
// Bit-serial restoring divider: 32-bit dividend by a narrow divisor.
module wkd_divider import wkd_pkg::*; #(
    parameter int DIVISOR_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [KEY_WIDTH-1:0]    i_dividend,
    input  logic [DIVISOR_BITS-1:0] i_divisor,
    output t_div_stat               o_stat,
    output logic [KEY_WIDTH-1:0]    o_quotient
);

    logic                    r_busy;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [KEY_WIDTH-1:0]    r_quo;
    logic [DIVISOR_BITS-1:0] r_rem;
    logic [DIVISOR_BITS-1:0] r_dvs;

    logic [DIVISOR_BITS:0]   rem_sh;
    logic [DIVISOR_BITS:0]   diff;
    logic                    ge;
    logic [DIVISOR_BITS-1:0] n_rem;
    logic [KEY_WIDTH-1:0]    n_quo;

    // one quotient bit per step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        rem_sh = {r_rem, r_quo[KEY_WIDTH-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        ge     = (rem_sh >= {1'b0, r_dvs});
        n_rem  = ge ? diff[DIVISOR_BITS-1:0] : rem_sh[DIVISOR_BITS-1:0];
        n_quo  = {r_quo[KEY_WIDTH-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.step = r_cnt;
    assign o_quotient  = r_quo;

endmodule

// File: rtl/core/ws_key_number_decoder_top.sv
// Top level of the handshake key number decoder.
// Takes one key header character per word on the input channel, one per cycle while ready is high.
// Digits '0'..'9' build an unsigned decimal number, spaces are counted
// (saturating at 2**SPACE_COUNT_BITS - 1), all other bytes are ignored.
// The word flagged last_char closes the key: the block then drops ready and
// runs a bit-serial restoring divider, one quotient bit per cycle, so input
// pauses for the 32 divider steps and until the result is loaded into the output
// register before the next key may start. The result word carries the
// quotient and a status: no spaces (value 0) wins over a number beyond
// 32 bits (value 0). The output register holds the result until taken, and
// characters of the next key are accepted meanwhile; a following last_char
// divides as usual and its result waits until the output register is free.
// All running state returns to zero after each key.
module ws_key_number_decoder_top import wkd_pkg::*; #(
    parameter int SPACE_COUNT_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    localparam logic S_ACC = 1'b0;
    localparam logic S_DIV = 1'b1;

    logic                        r_state;
    logic [KEY_WIDTH-1:0]        r_acc;
    logic                        r_ovf;
    logic [SPACE_COUNT_BITS-1:0] r_spc;
    logic [1:0]                  r_status;
    logic                        r_out_valid;
    t_out_word                   r_out;

    logic                        in_acc;
    logic                        is_digit;
    logic                        is_space;
    logic [3:0]                  digit;
    logic [KEY_WIDTH+3:0]        acc_x10;
    logic [KEY_WIDTH-1:0]        n_acc;
    logic                        n_ovf;
    logic [SPACE_COUNT_BITS-1:0] n_spc;
    logic [1:0]                  n_status;
    logic                        key_done;
    logic                        out_load;
    t_div_stat                   div_stat;
    logic [KEY_WIDTH-1:0]        quotient;

    assign o_in_ready = (r_state == S_ACC);
    assign in_acc     = i_in_valid && o_in_ready;
    assign key_done   = in_acc && i_in_data.last_char;

    // character decode and next running state
    always_comb begin
        is_digit = (i_in_data.key_char >= CHR_ZERO) && (i_in_data.key_char <= CHR_NINE);
        is_space = (i_in_data.key_char == CHR_SPACE);
        digit    = 4'(i_in_data.key_char - CHR_ZERO);
        acc_x10  = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                 + {(KEY_WIDTH)'(0), digit};
        n_acc    = r_acc;
        n_ovf    = r_ovf;
        n_spc    = r_spc;
        if (is_digit && !r_ovf) begin
            // freeze the number at its last in-range value
            if (acc_x10[KEY_WIDTH+3:KEY_WIDTH] != 4'd0) begin
                n_ovf = 1'b1;
            end else begin
                n_acc = acc_x10[KEY_WIDTH-1:0];
            end
        end else if (is_space && (r_spc != '1)) begin
            n_spc = r_spc + 1'b1;
        end
        priority if (n_spc == '0) begin
            n_status = ST_NO_SPACE;
        end else if (n_ovf) begin
            n_status = ST_OVERFLOW;
        end else begin
            n_status = ST_OK;
        end
    end

    wkd_divider #(
        .DIVISOR_BITS (SPACE_COUNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (key_done),
        .i_dividend (n_acc),
        .i_divisor  (n_spc),
        .o_stat     (div_stat),
        .o_quotient (quotient)
    );

    // load the result once the divider is through and the output slot is free
    assign out_load = (r_state == S_DIV) && !div_stat.busy && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_acc       <= '0;
            r_ovf       <= 1'b0;
            r_spc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (key_done) begin
                // clear running state for the next key
                r_acc   <= '0;
                r_ovf   <= 1'b0;
                r_spc   <= '0;
                r_state <= S_DIV;
            end else if (in_acc) begin
                r_acc <= n_acc;
                r_ovf <= n_ovf;
                r_spc <= n_spc;
            end else if (out_load) begin
                r_state <= S_ACC;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_done) begin
            r_status <= n_status;
        end
        if (out_load) begin
            r_out.key_value <= (r_status == ST_OK) ? quotient : '0;
            r_out.status    <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> !o_in_ready)
        else $error("input ready while divider busy");

    a_last_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        key_done |=> (div_stat.busy && (div_stat.step == '0) && (r_state == S_DIV)))
        else $error("divider not started after last character");

    a_last_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        key_done |=> ((r_acc == '0) && !r_ovf && (r_spc == '0)))
        else $error("running state not cleared after key");

    a_error_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ST_OK)) |-> (o_out_data.key_value == '0))
        else $error("nonzero key value with error status");
`endif

endmodule
